### hw/rtl/lev_pkg.sv
// ----------------------------------------------------------------------------
// Levenshtein distance package
// Request and response payload types, mode codes and the case fold used by
// the edit distance engine.
// ----------------------------------------------------------------------------
package lev_pkg;

   localparam logic [1:0] MODE_TEXT    = 2'd0;
   localparam logic [1:0] MODE_PATTERN = 2'd1;
   localparam logic [1:0] MODE_REPORT  = 2'd2;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] char_code;
   } req_type;

   typedef struct packed {
      logic [6:0] distance;
      logic       overflow;
   } rsp_type;

   function automatic logic [7:0] fold_case(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= 8'd97 && c <= 8'd122) begin
         r = c - 8'd32;
      end
      return r;
   endfunction

endpackage

### hw/rtl/lev_cell.sv
// ----------------------------------------------------------------------------
// Levenshtein row cell
// Holds one text byte and one entry of the distance row. A pattern byte
// arrives from the left neighbor with the old and new values of the entry to
// the left; the cell updates its entry and hands the wavefront on.
// ----------------------------------------------------------------------------
module lev_cell
   import lev_pkg::*;
#(
   parameter int INDEX = 1,
   parameter int DW    = 7
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          clear,
   input  logic          wr_en,
   input  logic [7:0]    wr_char,
   input  logic          in_valid,
   input  logic [7:0]    in_char,
   input  logic [DW-1:0] in_diag,
   input  logic [DW-1:0] in_left,
   output logic          out_valid,
   output logic [7:0]    out_char,
   output logic [DW-1:0] out_diag,
   output logic [DW-1:0] out_left
);

   logic          active_ff, active_in;
   logic          valid_ff, valid_in;
   logic [7:0]    text_ff, text_in;
   logic [7:0]    char_ff, char_in;
   logic [DW-1:0] d_ff, d_in;
   logic [DW-1:0] diag_ff, diag_in;
   logic [DW-1:0] left_ff, left_in;
   logic [DW-1:0] low2, low3, cand;

   always_comb begin
      low2 = (in_diag < d_ff) ? in_diag : d_ff;
      low3 = (low2 < in_left) ? low2 : in_left;
      cand = (in_char == text_ff) ? in_diag : low3 + DW'(1);

      active_in = active_ff | wr_en;
      text_in   = wr_en ? wr_char : text_ff;
      valid_in  = in_valid;
      char_in   = in_char;
      d_in      = d_ff;
      diag_in   = in_diag;
      left_in   = in_left;
      if (in_valid && active_ff) begin
         d_in    = cand;
         diag_in = d_ff;
         left_in = cand;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         active_ff <= 1'b0;
         valid_ff  <= 1'b0;
         d_ff      <= DW'(INDEX);
      end else begin
         active_ff <= active_in;
         valid_ff  <= valid_in;
         d_ff      <= d_in;
      end
      text_ff <= text_in;
      char_ff <= char_in;
      diag_ff <= diag_in;
      left_ff <= left_in;
   end

   assign out_valid = valid_ff;
   assign out_char  = char_ff;
   assign out_diag  = diag_ff;
   assign out_left  = left_ff;

endmodule

### hw/rtl/levenshtein_distance.sv
// ----------------------------------------------------------------------------
// Levenshtein distance engine
// Case-insensitive edit distance between a stored text and a pattern,
// computed by a systolic row of text cells.
// ----------------------------------------------------------------------------
//   Channel   Direction   Payload    Role
//   req_      in          req_type   text byte, pattern byte or report
//   rsp_      out         rsp_type   distance and overflow flag per report
//
// Text and pattern requests are taken one per cycle outside a report drain;
// a pattern byte moves through the cell row one cell per cycle as a wavefront.
// A report waits until all wavefronts have left the row and for as long as
// the previous response is still held.
// Reset clears the row; a report clears it when its response is loaded. A
// held response does not stop text and pattern requests.
module levenshtein_distance
   import lev_pkg::*;
#(
   parameter int MAX_TEXT    = 64,
   parameter int MAX_PATTERN = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int MAXLEN = (MAX_TEXT > MAX_PATTERN) ? MAX_TEXT : MAX_PATTERN;
   localparam int DW     = $clog2(MAXLEN + 1);
   localparam int TLW    = $clog2(MAX_TEXT + 1);
   localparam int PCW    = $clog2(MAX_PATTERN + 1);

   typedef enum logic {ST_RUN, ST_DRAIN} state_type;

   state_type      state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_ff, rsp_in;
   logic [TLW-1:0] text_length_ff, text_length_in;
   logic [PCW-1:0] pattern_count_ff, pattern_count_in;
   logic           overflow_ff, overflow_in;
   logic [TLW-1:0] inflight_ff, inflight_in;
   logic [DW-1:0]  last_d_ff, last_d_in;

   logic           accept, text_wr, inject, clear;
   logic [7:0]     folded;
   logic [PCW-1:0] pc_next;
   logic [10:0]    dist_wide;

   logic           ch_valid [0:MAX_TEXT];
   logic [7:0]     ch_char  [0:MAX_TEXT];
   logic [DW-1:0]  ch_diag  [0:MAX_TEXT];
   logic [DW-1:0]  ch_left  [0:MAX_TEXT];

   assign req_ready = (state_ff == ST_RUN);
   assign accept    = req_valid && req_ready;
   assign folded    = fold_case(req_data.char_code);
   assign pc_next   = pattern_count_ff + PCW'(1);

   assign text_wr = accept && (req_data.mode == MODE_TEXT) && (pattern_count_ff == '0)
                    && (text_length_ff < TLW'(MAX_TEXT));
   assign inject  = accept && (req_data.mode == MODE_PATTERN)
                    && (pattern_count_ff < PCW'(MAX_PATTERN));

   assign ch_valid[0] = inject;
   assign ch_char[0]  = folded;
   assign ch_diag[0]  = DW'(pattern_count_ff);
   assign ch_left[0]  = DW'(pc_next);

   for (genvar j = 1; j <= MAX_TEXT; j++) begin : g_cell
      lev_cell #(
         .INDEX(j),
         .DW   (DW)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .clear    (clear),
         .wr_en    (text_wr && (text_length_ff == TLW'(j - 1))),
         .wr_char  (folded),
         .in_valid (ch_valid[j-1]),
         .in_char  (ch_char[j-1]),
         .in_diag  (ch_diag[j-1]),
         .in_left  (ch_left[j-1]),
         .out_valid(ch_valid[j]),
         .out_char (ch_char[j]),
         .out_diag (ch_diag[j]),
         .out_left (ch_left[j])
      );
   end

   always_comb begin
      state_in         = state_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_in           = rsp_ff;
      text_length_in   = text_length_ff;
      pattern_count_in = pattern_count_ff;
      overflow_in      = overflow_ff;
      inflight_in      = inflight_ff + TLW'(inject) - TLW'(ch_valid[MAX_TEXT]);
      last_d_in        = ch_valid[MAX_TEXT] ? ch_left[MAX_TEXT] : last_d_ff;
      clear            = 1'b0;
      dist_wide        = (pattern_count_ff == '0) ? 11'(text_length_ff) : 11'(last_d_ff);

      unique case (state_ff)
         ST_RUN: begin
            if (accept) begin
               priority if (req_data.mode == MODE_TEXT) begin
                  if (text_wr) begin
                     text_length_in = text_length_ff + TLW'(1);
                  end else if (pattern_count_ff == '0) begin
                     overflow_in = 1'b1;
                  end
               end else if (req_data.mode == MODE_PATTERN) begin
                  if (inject) begin
                     pattern_count_in = pc_next;
                  end else begin
                     overflow_in = 1'b1;
                  end
               end else if (req_data.mode == MODE_REPORT) begin
                  state_in = ST_DRAIN;
               end else begin
                  state_in = ST_RUN;
               end
            end
         end
         ST_DRAIN: begin
            if (inflight_ff == '0 && (!rsp_valid_ff || rsp_ready)) begin
               clear             = 1'b1;
               rsp_valid_in      = 1'b1;
               rsp_in.distance   = (dist_wide > 11'd127) ? 7'd127 : dist_wide[6:0];
               rsp_in.overflow   = overflow_ff;
               text_length_in    = '0;
               pattern_count_in  = '0;
               overflow_in       = 1'b0;
               state_in          = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_RUN;
         rsp_valid_ff     <= 1'b0;
         text_length_ff   <= '0;
         pattern_count_ff <= '0;
         overflow_ff      <= 1'b0;
         inflight_ff      <= '0;
      end else begin
         state_ff         <= state_in;
         rsp_valid_ff     <= rsp_valid_in;
         text_length_ff   <= text_length_in;
         pattern_count_ff <= pattern_count_in;
         overflow_ff      <= overflow_in;
         inflight_ff      <= inflight_in;
      end
      rsp_ff    <= rsp_in;
      last_d_ff <= last_d_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
